>>> rtl/cahr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cahr_pkg: shared types and constants for the client allow-list registry
// Request and response beats, table entry layout and group unit control.
// ----------------------------------------------------------------------------
package cahr_pkg;

	localparam int KEY_W   = 32;
	localparam int GRP_W   = 3;
	localparam int SLOT_W  = 14;
	localparam int COUNT_W = 15;

	localparam logic [KEY_W-1:0]   KEY_HASH_MASK = 32'h7fff_ffff;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 15'h7fff;

	typedef enum logic [1:0] {
		ACT_LOAD      = 2'd0,
		ACT_HEARTBEAT = 2'd1,
		ACT_DROP      = 2'd2,
		ACT_LOOKUP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_UNKNOWN    = 3'd0,
		ST_ALLOWED    = 3'd1,
		ST_REGISTERED = 3'd2,
		ST_NEW_REG    = 3'd3,
		ST_DROPPED    = 3'd4,
		ST_LOADED     = 3'd5,
		ST_FULL       = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] client_key;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [GRP_W-1:0]  group;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic             registered;
		logic [GRP_W-1:0] group;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic             inc;
		logic             dec;
		logic [GRP_W-1:0] idx;
	} grp_cmd_t;

	typedef struct packed {
		logic             done;
		logic [GRP_W-1:0] best;
	} grp_stat_t;

endpackage

>>> rtl/client_allowlist_hash_registry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_allowlist_hash_registry: allow-list of 32-bit client addresses
// Open-addressing hash table with quadratic probing and group balancing.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat {action, client_key} is taken on a rising edge with start
//   high and busy low. Exactly one response beat {status, group, slot} follows,
//   shown for one cycle with done high; it cannot be held off, so capture it.
//   Actions: load an allowed key, heartbeat (register and assign the least
//   loaded group), drop (unregister), lookup.
// Timing:
//   Each slot examined costs one read of the entry store's read port.
//   The response is registered once the last slot of the chain is examined,
//   and busy falls in that same cycle, so a new request may go in alongside
//   the response. A heartbeat that newly registers a key adds the serial
//   least-loaded search over the group counters.
// Reset:
//   arst_n clears the counters and starts a clearing pass over every entry of
//   the entry store, one entry a cycle; busy stays high until it ends.
// ----------------------------------------------------------------------------
module client_allowlist_hash_registry #(
	parameter int TABLE_SLOTS = 16384,
	parameter int GROUPS      = 5,
	parameter int PROBE_LIMIT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cahr_pkg::req_t  req,
	output logic            done,
	output cahr_pkg::rsp_t  rsp
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int KW = $clog2(PROBE_LIMIT + 1);
	localparam int SW = cahr_pkg::SLOT_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE,
		S_SEARCH
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             clr_q;
	logic [IW-1:0]             pos_q;
	logic [IW-1:0]             sq_q;
	logic [KW-1:0]             k_q;
	logic [cahr_pkg::KEY_W-1:0] key_q;
	logic [1:0]                act_q;
	logic                      done_q;
	cahr_pkg::rsp_t            rsp_q;

	cahr_pkg::entry_t    ent;
	cahr_pkg::entry_t    wr_data;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	cahr_pkg::grp_cmd_t  gcmd;
	cahr_pkg::grp_stat_t gstat;

	logic [cahr_pkg::KEY_W-1:0] key_hashed;
	logic [IW-1:0]              home;
	logic [IW-1:0]              pos_nxt;
	logic [IW-1:0]              sq_nxt;
	logic                       is_empty;
	logic                       is_match;
	logic                       at_limit;
	logic                       chain_end;
	logic                       need_search;
	cahr_pkg::rsp_t             rsp_nxt;

	assign key_hashed = req.client_key & cahr_pkg::KEY_HASH_MASK;
	assign home       = key_hashed[IW-1:0];
	assign pos_nxt    = pos_q + sq_q;
	// (k+1)^2 = k^2 + 2k + 1, all modulo the table size
	assign sq_nxt     = sq_q + IW'({k_q, 1'b1});

	assign is_empty    = !ent.valid;
	assign is_match    = ent.valid && (ent.key == key_q);
	assign at_limit    = !is_empty && !is_match && (k_q == KW'(PROBE_LIMIT));
	assign chain_end   = is_empty || is_match || at_limit;
	assign need_search = is_match && (act_q == cahr_pkg::ACT_HEARTBEAT) && !ent.registered;

	always_comb begin
		rsp_nxt.status = cahr_pkg::ST_UNKNOWN;
		rsp_nxt.group  = '0;
		rsp_nxt.slot   = '0;
		if (act_q == cahr_pkg::ACT_LOAD) begin
			if (is_empty || is_match) begin
				rsp_nxt.status = cahr_pkg::ST_LOADED;
				rsp_nxt.slot   = SW'(pos_q);
				if (is_match && ent.registered) begin
					rsp_nxt.group = ent.group;
				end
			end else begin
				rsp_nxt.status = cahr_pkg::ST_FULL;
			end
		end else if (is_match) begin
			rsp_nxt.slot = SW'(pos_q);
			case (act_q)
				cahr_pkg::ACT_DROP: begin
					if (ent.registered) begin
						rsp_nxt.status = cahr_pkg::ST_DROPPED;
						rsp_nxt.group  = ent.group;
					end else begin
						rsp_nxt.status = cahr_pkg::ST_ALLOWED;
					end
				end
				default: begin
					// heartbeat of a registered key reports like a lookup
					if (ent.registered) begin
						rsp_nxt.status = cahr_pkg::ST_REGISTERED;
						rsp_nxt.group  = ent.group;
					end else begin
						rsp_nxt.status = cahr_pkg::ST_ALLOWED;
					end
				end
			endcase
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = home;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '0;
		gcmd    = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				rd_en = start;
			end
			S_PROBE: begin
				if (!chain_end) begin
					rd_en   = 1'b1;
					rd_addr = pos_nxt;
				end else if (is_empty && act_q == cahr_pkg::ACT_LOAD) begin
					wr_en         = 1'b1;
					wr_data.valid = 1'b1;
					wr_data.key   = key_q;
				end else if (is_match && act_q == cahr_pkg::ACT_DROP && ent.registered) begin
					wr_en         = 1'b1;
					wr_data.valid = 1'b1;
					wr_data.key   = key_q;
					gcmd.dec      = 1'b1;
					gcmd.idx      = ent.group;
				end else if (need_search) begin
					gcmd.start = 1'b1;
				end
			end
			S_SEARCH: begin
				if (gstat.done) begin
					wr_en              = 1'b1;
					wr_data.valid      = 1'b1;
					wr_data.registered = 1'b1;
					wr_data.group      = gstat.best;
					wr_data.key        = key_q;
					gcmd.inc           = 1'b1;
					gcmd.idx           = gstat.best;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pos_q   <= '0;
			sq_q    <= '0;
			k_q     <= '0;
			key_q   <= '0;
			act_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						pos_q   <= home;
						sq_q    <= IW'(1);
						k_q     <= KW'(1);
						key_q   <= req.client_key;
						act_q   <= req.action;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (!chain_end) begin
						pos_q <= pos_nxt;
						sq_q  <= sq_nxt;
						k_q   <= k_q + KW'(1);
					end else if (need_search) begin
						state_q <= S_SEARCH;
					end else begin
						done_q  <= 1'b1;
						rsp_q   <= rsp_nxt;
						state_q <= S_IDLE;
					end
				end
				S_SEARCH: begin
					if (gstat.done) begin
						done_q       <= 1'b1;
						rsp_q.status <= cahr_pkg::ST_NEW_REG;
						rsp_q.group  <= gstat.best;
						rsp_q.slot   <= SW'(pos_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	cahr_mem #(
		.DEPTH (TABLE_SLOTS),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	cahr_grp #(
		.GROUPS (GROUPS)
	) u_grp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (gcmd),
		.stat   (gstat)
	);

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response beat lasted more than one cycle");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (k_q != '0) && (k_q <= KW'(PROBE_LIMIT)))
		else $error("probe count outside the limit");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == cahr_pkg::ST_FULL) |-> (rsp.group == '0 && rsp.slot == '0))
		else $error("table full response carries a slot or group");

	a_search_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> !done)
		else $error("response during group search");
`endif

endmodule

>>> rtl/cahr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cahr_mem: entry store
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module cahr_mem #(
	parameter int DEPTH = 16384,
	parameter int IW    = 14
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_addr,
	output cahr_pkg::entry_t  rd_data,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_addr,
	input  cahr_pkg::entry_t  wr_data
);

	cahr_pkg::entry_t mem_q [DEPTH];
	cahr_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/cahr_grp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cahr_grp: group load counters
// Saturating per-group counts and a serial least-loaded search, one group
// a cycle, lowest index winning ties.
// ----------------------------------------------------------------------------
module cahr_grp #(
	parameter int GROUPS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cahr_pkg::grp_cmd_t   cmd,
	output cahr_pkg::grp_stat_t  stat
);

	localparam int GIW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GW  = cahr_pkg::GRP_W;
	localparam int CW  = cahr_pkg::COUNT_W;
	// one bit wider than a group index so that a full set of eight still fits
	localparam logic [GW:0] GROUPS_X = (GW+1)'(GROUPS);

	logic [CW-1:0]  counts_q [GROUPS];
	logic           busy_q;
	logic           first_q;
	logic           done_q;
	logic [GIW-1:0] scan_q;
	logic [GIW-1:0] best_q;
	logic [CW-1:0]  best_cnt_q;

	logic [GIW-1:0] addr;
	logic [CW-1:0]  cnt;
	logic           take;
	logic [GIW-1:0] best_nxt;
	logic           idx_ok;

	assign addr     = busy_q ? scan_q : cmd.idx[GIW-1:0];
	assign cnt      = counts_q[addr];
	assign take     = first_q || (cnt < best_cnt_q);
	assign best_nxt = take ? scan_q : best_q;
	assign idx_ok   = ({1'b0, cmd.idx} < GROUPS_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			first_q    <= 1'b0;
			done_q     <= 1'b0;
			scan_q     <= '0;
			best_q     <= '0;
			best_cnt_q <= '0;
			for (int i = 0; i < GROUPS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				first_q <= 1'b0;
				best_q  <= best_nxt;
				if (take) begin
					best_cnt_q <= cnt;
				end
				if (scan_q == GIW'(GROUPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					scan_q <= scan_q + GIW'(1);
				end
			end else if (cmd.start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				scan_q  <= '0;
			end else if (cmd.inc && idx_ok) begin
				if (cnt < cahr_pkg::COUNT_MAX) begin
					counts_q[addr] <= cnt + CW'(1);
				end
			end else if (cmd.dec && idx_ok) begin
				if (cnt != '0) begin
					counts_q[addr] <= cnt - CW'(1);
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.best = GW'(best_q);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("search done while still scanning");

	a_no_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(cmd.start || cmd.inc || cmd.dec))
		else $error("group command during search");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, stat.best} < GROUPS_X))
		else $error("least-loaded group out of range");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the client allow-list hash registry
// Drives request beats from a queue of pending requests, predicts each
// response with a behavioural copy of the table and group counters, and
// compares every response beat with the oldest prediction. Traffic mixes
// key lifecycles, collision-heavy homes, probe-chain floods and noise.
// ----------------------------------------------------------------------------
module tb_top;
	import cahr_pkg::*;

	localparam int TABLE_SLOTS  = 16384;
	localparam int GROUPS       = 5;
	localparam int PROBE_LIMIT  = 64;
	localparam int ITEMS        = 1550;
	localparam int TAIL_ITEMS   = 150;
	localparam int QUIET_LIMIT  = 4 * (TABLE_SLOTS + 4 * PROBE_LIMIT);
	localparam int DRAIN_CYCLES = PROBE_LIMIT + GROUPS + 16;
	localparam int MAX_REPORTS  = 40;

	typedef enum logic [1:0] {
		CHAIN_EMPTY,
		CHAIN_MATCH,
		CHAIN_EXHAUSTED
	} chain_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	entry_t            slot_store [TABLE_SLOTS] = '{default: '0};
	logic [COUNT_W-1:0] grp_load  [GROUPS]      = '{default: '0};

	int unsigned accepted = 0;
	int unsigned responses = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned status_tally [8] = '{default: 0};
	int unsigned seen_beats = 0;
	int unsigned idle_left = 0;
	rsp_t want_rsp;

	client_allowlist_hash_registry #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.GROUPS     (GROUPS),
		.PROBE_LIMIT(PROBE_LIMIT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #2 clk = ~clk;

	// Apply one request to the shadow table and return the response it earns.
	function automatic rsp_t registry_step(input action_t act, input logic [KEY_W-1:0] key);
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W-1:0] at;
		chain_end_t outcome;
		logic searching;
		int k;
		int g;
		rsp_t r;
		pos = SLOT_W'((key & KEY_HASH_MASK) % TABLE_SLOTS);
		at = '0;
		outcome = CHAIN_EXHAUSTED;
		searching = 1'b1;
		for (k = 1; k <= PROBE_LIMIT; k++) begin
			if (searching) begin
				if (!slot_store[pos].valid) begin
					outcome = CHAIN_EMPTY;
					at = pos;
					searching = 1'b0;
				end else if (slot_store[pos].key == key) begin
					outcome = CHAIN_MATCH;
					at = pos;
					searching = 1'b0;
				end else begin
					pos = pos + SLOT_W'(k * k);
				end
			end
		end

		r = '0;
		r.status = ST_UNKNOWN;
		if (act == ACT_LOAD) begin
			if (outcome == CHAIN_EMPTY) begin
				slot_store[at] = '{valid: 1'b1, registered: 1'b0, group: '0, key: key};
				r.status = ST_LOADED;
				r.slot = at;
			end else if (outcome == CHAIN_MATCH) begin
				r.status = ST_LOADED;
				r.slot = at;
				r.group = slot_store[at].registered ? slot_store[at].group : '0;
			end else begin
				r.status = ST_FULL;
			end
		end else if (outcome == CHAIN_MATCH) begin
			r.slot = at;
			case (act)
			ACT_HEARTBEAT: begin
				if (slot_store[at].registered) begin
					r.status = ST_REGISTERED;
					r.group = slot_store[at].group;
				end else begin
					// lowest count wins, first index on a tie
					g = 0;
					for (k = 1; k < GROUPS; k++)
						if (grp_load[k] < grp_load[g]) g = k;
					if (grp_load[g] < COUNT_MAX) grp_load[g]++;
					slot_store[at].registered = 1'b1;
					slot_store[at].group = GRP_W'(g);
					r.status = ST_NEW_REG;
					r.group = GRP_W'(g);
				end
			end
			ACT_DROP: begin
				if (slot_store[at].registered) begin
					g = slot_store[at].group;
					if (g < GROUPS && grp_load[g] != '0) grp_load[g]--;
					slot_store[at].registered = 1'b0;
					slot_store[at].group = '0;
					r.status = ST_DROPPED;
					r.group = GRP_W'(g);
				end else begin
					r.status = ST_ALLOWED;
				end
			end
			default: begin
				if (slot_store[at].registered) begin
					r.status = ST_REGISTERED;
					r.group = slot_store[at].group;
				end else begin
					r.status = ST_ALLOWED;
				end
			end
			endcase
		end
		return r;
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch on response %0d: expected %0d, actual %0d",
					$time, what, responses, want, got);
		end
	endfunction

	task automatic queue_req(input action_t act, input logic [KEY_W-1:0] key);
		req_t r;
		r.action = act;
		r.client_key = key;
		pending_reqs.push_back(r);
	endtask

	// Response checking and request capture, both at the rising edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected response: expected none, actual %0d/%0d/%0d",
						$time, rsp.status, rsp.group, rsp.slot);
			end else begin
				want_rsp = expected_rsps.pop_front();
				check_field("status", want_rsp.status, rsp.status);
				check_field("group", want_rsp.group, rsp.group);
				check_field("slot", want_rsp.slot, rsp.slot);
				status_tally[want_rsp.status]++;
			end
			responses++;
		end
		if (arst_n && start && !busy) begin
			expected_rsps.push_back(registry_step(action_t'(req.action), req.client_key));
			void'(pending_reqs.pop_front());
			accepted++;
		end
		if (arst_n && (done || (start && !busy)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Request driver: hold a beat until taken, then idle in bursts or present the next.
	always @(negedge clk) begin
		if (arst_n && !(start && accepted == seen_beats)) begin
			seen_beats = accepted;
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() > TAIL_ITEMS &&
					$urandom_range(0, 99) < (accepted / 200) % 3 * 20) begin
				idle_left = $urandom_range(1, 6) - 1;
				start <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				start <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		logic [SLOT_W-1:0] hot_home [8];
		logic [KEY_W-1:0] key_pool [$];
		logic [KEY_W-1:0] key;
		logic [SLOT_W-1:0] home;
		action_t act;
		int pick;
		int floods;
		int n;

		// directed: empty table, duplicate load, full lifecycle, masked top bit, wrap
		queue_req(ACT_LOOKUP, 32'h0000_0000);
		queue_req(ACT_LOAD, 32'h0000_0000);
		queue_req(ACT_LOAD, 32'h0000_0000);
		queue_req(ACT_LOOKUP, 32'h0000_0000);
		queue_req(ACT_DROP, 32'h0000_0000);
		queue_req(ACT_HEARTBEAT, 32'h0000_0000);
		queue_req(ACT_HEARTBEAT, 32'h0000_0000);
		queue_req(ACT_LOAD, 32'h0000_0000);
		queue_req(ACT_LOOKUP, 32'h0000_0000);
		queue_req(ACT_DROP, 32'h0000_0000);
		queue_req(ACT_LOAD, 32'hffff_ffff);
		queue_req(ACT_LOAD, 32'h7fff_ffff);
		queue_req(ACT_HEARTBEAT, 32'hffff_ffff);
		queue_req(ACT_HEARTBEAT, 32'h7fff_ffff);
		queue_req(ACT_LOOKUP, 32'h7fff_ffff);
		queue_req(ACT_DROP, 32'h7fff_ffff);
		queue_req(ACT_DROP, 32'h8000_0000);
		queue_req(ACT_HEARTBEAT, 32'h1234_5678);
		queue_req(ACT_LOOKUP, 32'h8000_3fff);

		floods = 0;
		for (n = 0; n < 8; n++) hot_home[n] = SLOT_W'($urandom);
		while (pending_reqs.size() < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2 && floods < 4) begin
				// fill one probe chain past its limit, then ask for keys it cannot hold
				floods++;
				home = SLOT_W'($urandom);
				for (n = 0; n < PROBE_LIMIT + 6; n++) begin
					key = $urandom;
					key[SLOT_W-1:0] = home;
					queue_req(ACT_LOAD, key);
					if (n % 16 == 0 && key_pool.size() < 400) key_pool.push_back(key);
				end
				key = $urandom;
				key[SLOT_W-1:0] = home;
				queue_req(ACT_HEARTBEAT, key);
				queue_req(ACT_DROP, key);
				queue_req(ACT_LOOKUP, key);
			end else if (pick < 30) begin
				key = $urandom;
				if ($urandom_range(0, 9) < 7) key[SLOT_W-1:0] = hot_home[$urandom_range(0, 7)];
				queue_req(ACT_LOAD, key);
				queue_req(ACT_HEARTBEAT, key);
				queue_req(ACT_LOOKUP, key);
				queue_req(ACT_HEARTBEAT, key);
				queue_req(ACT_DROP, key);
				queue_req(ACT_LOOKUP, key);
				if (key_pool.size() < 400) key_pool.push_back(key);
			end else if (pick < 85 && key_pool.size() != 0) begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				pick = $urandom_range(0, 99);
				if (pick < 10)
					act = ACT_LOAD;
				else if (pick < 50)
					act = ACT_HEARTBEAT;
				else if (pick < 80)
					act = ACT_DROP;
				else
					act = ACT_LOOKUP;
				queue_req(act, key);
			end else begin
				queue_req(action_t'($urandom_range(0, 3)), $urandom);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// the clearing pass after reset counts against the quiet limit too
		while ((pending_reqs.size() != 0 || expected_rsps.size() != 0) &&
				quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		if (quiet_cycles < QUIET_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses, %0d field errors.",
			accepted, responses, errors);
		$display("Loaded %0d, table full %0d, new regs %0d, dropped %0d, unknown %0d.",
			status_tally[ST_LOADED], status_tally[ST_FULL], status_tally[ST_NEW_REG],
			status_tally[ST_DROPPED], status_tally[ST_UNKNOWN]);
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timed out after %0d cycles without a beat.", quiet_cycles);
			$display("SCOREBOARD MISMATCH");
		end else if (errors == 0 && expected_rsps.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
